### sv/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// shared constants, types and state codes of the spectrum smoother
// ----------------------------------------------------------------------------
package ssa_pkg;

    // sizes
    localparam int NUM_BINS    = 64;
    localparam int NUM_WINDOWS = 4;
    localparam int BIN_W       = $clog2(NUM_BINS);
    localparam int SLOT_W      = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

    // field widths
    localparam int MAG_W     = 24;
    localparam int MS_W      = 16;
    localparam int IDX_W     = 6;
    localparam int TIMER_W   = 17;
    localparam int PROD_W    = MAG_W + MS_W;
    localparam int CFG_IDX_W = 2;
    localparam int QUO_CNT_W = $clog2(MAG_W);

    // constants, magnitudes in unsigned q16.8
    localparam logic [TIMER_W-1:0] WINDOW_MS    = 17'd1000;
    localparam logic [MS_W-1:0]    SCALE_TC_MS  = 16'd450;
    localparam logic [MS_W-1:0]    SMOOTH_RESET = 16'd100;
    localparam logic [MAG_W-1:0]   AMP_FLOOR    = 24'd5120;
    localparam logic [MAG_W-1:0]   AMP_RESET    = 24'd256000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIXED_SCALE    = 2'd0,
        REG_USER_AMPLITUDE = 2'd1,
        REG_SMOOTHING_TIME = 2'd2
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_BIN_WB,
        ST_WIN,
        ST_MAX,
        ST_AUTO,
        ST_SCALE_WB,
        ST_OUT
    } state_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

### sv/ssa_div.sv
// ----------------------------------------------------------------------------
// ssa_div
// restoring divider, one quotient bit per cycle, 24-bit quotient
// ----------------------------------------------------------------------------
module ssa_div
    import ssa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,   // upper MS_W bits below divisor
    input  logic [MS_W-1:0]   divisor,
    output logic [MAG_W-1:0]  quotient,
    output div_sts_t          sts
);

    logic                 running_reg;
    logic                 done_reg;
    logic [QUO_CNT_W-1:0] cnt_reg;
    logic [MS_W-1:0]      rem_reg;
    logic [MAG_W-1:0]     quo_reg;

    logic [MS_W:0]        trial_num;
    logic [MS_W:0]        trial_diff;
    logic                 q_bit;

    // shift next dividend bit into partial remainder and try subtract
    assign trial_num  = {rem_reg, quo_reg[MAG_W-1]};
    assign trial_diff = trial_num - {1'b0, divisor};
    assign q_bit      = (trial_num >= {1'b0, divisor});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                running_reg <= 1'b1;
                cnt_reg     <= '0;
            end else if (running_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == QUO_CNT_W'(MAG_W - 1)) begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[PROD_W-1:MAG_W];
            quo_reg <= dividend[MAG_W-1:0];
        end else if (running_reg) begin
            rem_reg <= q_bit ? trial_diff[MS_W-1:0] : trial_num[MS_W-1:0];
            quo_reg <= {quo_reg[MAG_W-2:0], q_bit};
        end
    end

    assign quotient = quo_reg;
    assign sts.busy = running_reg;
    assign sts.done = done_reg;

    a_done_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !running_reg)
        else $error("divider done while still running");

endmodule

### sv/spectrum_smoother_autorange_top.sv
// ----------------------------------------------------------------------------
// spectrum_smoother_autorange_top
// per-bin exponential smoothing with auto-ranging peak hold and display scale
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         s_valid/s_ready    bin_value, elapsed_ms
//  m_*       out        m_valid/m_ready    smoothed_bin, bin_index, frame_done,
//                                          display_scale, auto_amplitude
//  cfg_*     in         cfg_wr_en          cfg_index, cfg_wdata (write only)
//
//  one bin at a time: the blend goes through the multiplier and then the divider;
//  the divider is skipped when the weight saturates (elapsed >= time const)
//  the last bin of a frame adds window, auto level and a second blend through the
//  same multiplier and divider, whose divide is skipped when the scale weight saturates
//  reset is synchronous; the bin store needs no clearing pass (valid bits)
//  a stalled m_ready holds the result register, and the sequencer in ST_OUT once the
//  next result is ready; a new transaction is taken while the previous result waits
// ----------------------------------------------------------------------------
module spectrum_smoother_autorange_top
    import ssa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MAG_W-1:0]     cfg_wdata,

    // bin input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [MAG_W-1:0]     s_bin_value,
    input  logic [MS_W-1:0]      s_elapsed_ms,

    // result output
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [MAG_W-1:0]     m_smoothed_bin,
    output logic [IDX_W-1:0]     m_bin_index,
    output logic                 m_frame_done,
    output logic [MAG_W-1:0]     m_display_scale,
    output logic [MAG_W-1:0]     m_auto_amplitude
);

    // configuration registers
    logic                fixed_scale_reg;
    logic [MAG_W-1:0]    user_amp_reg;
    logic [MS_W-1:0]     smooth_ms_reg;

    // sequencer
    state_t              state_reg;
    state_t              state_next;
    logic                phase_reg;      // 0: bin blend, 1: scale blend
    logic                in_accept;
    logic                div_start;
    logic                out_load;

    // frame state
    logic [BIN_W-1:0]    bin_counter_reg;
    logic [MAG_W-1:0]    frame_peak_reg;
    logic [TIMER_W-1:0]  win_timer_reg;
    logic [SLOT_W-1:0]   win_slot_reg;
    logic [MAG_W-1:0]    win_max_reg [NUM_WINDOWS];
    logic [MAG_W-1:0]    auto_level_reg;
    logic [MAG_W-1:0]    scale_level_reg;
    logic [MAG_W-1:0]    win_peak_reg;

    // bin store, valid bit per entry stands in for the zero reset
    logic [MAG_W-1:0]    bin_mem [NUM_BINS];
    logic [MAG_W-1:0]    rd_data_reg;
    logic                bin_valid_reg [NUM_BINS];

    // blend datapath
    logic [MAG_W-1:0]    fresh_reg;
    logic [MAG_W-1:0]    old_reg;
    logic [MS_W-1:0]     e_reg;
    logic [PROD_W-1:0]   prod_a_reg;
    logic [PROD_W-1:0]   prod_b_reg;
    logic [MAG_W-1:0]    result_reg;
    logic [MS_W-1:0]     blend_t;
    logic [MS_W-1:0]     blend_rest;
    logic                blend_bypass;
    logic [MAG_W-1:0]    div_quo;
    div_sts_t            div_sts;

    // result staging and output register
    logic [MAG_W-1:0]    smoothed_stage_reg;
    logic [IDX_W-1:0]    index_stage_reg;
    logic                done_stage_reg;
    logic                m_valid_reg;
    logic [MAG_W-1:0]    m_smoothed_reg;
    logic [IDX_W-1:0]    m_index_reg;
    logic                m_done_reg;
    logic [MAG_W-1:0]    m_scale_reg;
    logic [MAG_W-1:0]    m_auto_reg;

    // frame end arithmetic
    logic                last_bin;
    logic [TIMER_W-1:0]  timer_sum;
    logic                win_rotate;
    logic [SLOT_W-1:0]   slot_inc;
    logic [SLOT_W-1:0]   slot_new;
    logic [MAG_W-1:0]    win_peak;
    logic [MAG_W+3:0]    peak_x10;
    logic [MAG_W+3:0]    auto_x3;
    logic [MAG_W-1:0]    auto_hyst;
    logic [MAG_W-1:0]    auto_new;

    // ------------------------------------------------------------------
    // configuration port, unknown index ignored
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fixed_scale_reg <= 1'b0;
            user_amp_reg    <= AMP_RESET;
            smooth_ms_reg   <= SMOOTH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FIXED_SCALE:    fixed_scale_reg <= cfg_wdata[0];
                REG_USER_AMPLITUDE: user_amp_reg    <= cfg_wdata;
                REG_SMOOTHING_TIME: smooth_ms_reg   <= cfg_wdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // blend: floor((e*new + (t-e)*old) / t), or new when e >= t
    // ------------------------------------------------------------------
    assign blend_t      = phase_reg ? SCALE_TC_MS : smooth_ms_reg;
    assign blend_bypass = (e_reg >= blend_t);
    assign blend_rest   = blend_t - e_reg;

    ssa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_a_reg + prod_b_reg),
        .divisor  (blend_t),
        .quotient (div_quo),
        .sts      (div_sts)
    );

    // ------------------------------------------------------------------
    // frame end: window timer, slot rotation, peak search, hysteresis
    // ------------------------------------------------------------------
    assign last_bin   = (bin_counter_reg == BIN_W'(NUM_BINS - 1));
    assign timer_sum  = win_timer_reg + {1'b0, e_reg};
    assign win_rotate = (timer_sum > WINDOW_MS);
    assign slot_inc   = (win_slot_reg == SLOT_W'(NUM_WINDOWS - 1)) ? '0
                                                                   : win_slot_reg + 1'b1;
    assign slot_new   = win_rotate ? slot_inc : win_slot_reg;

    always_comb begin
        win_peak = '0;
        for (int i = 0; i < NUM_WINDOWS; i++) begin
            if (win_max_reg[i] > win_peak) begin
                win_peak = win_max_reg[i];
            end
        end
    end

    // drop only when peak falls below 0.30 of the current level
    assign peak_x10  = ({4'b0, win_peak_reg} << 3) + ({4'b0, win_peak_reg} << 1);
    assign auto_x3   = ({4'b0, auto_level_reg} << 1) + {4'b0, auto_level_reg};
    assign auto_hyst = ((peak_x10 < auto_x3) || (win_peak_reg > auto_level_reg))
                       ? win_peak_reg : auto_level_reg;
    assign auto_new  = (auto_hyst < AMP_FLOOR) ? AMP_FLOOR : auto_hyst;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:     state_next = ST_MUL_A;
            ST_MUL_A:    state_next = ST_MUL_B;
            ST_MUL_B:    state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: begin
                if (blend_bypass) begin
                    state_next = phase_reg ? ST_SCALE_WB : ST_BIN_WB;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_sts.done) begin
                    state_next = phase_reg ? ST_SCALE_WB : ST_BIN_WB;
                end
            end
            ST_BIN_WB:   state_next = last_bin ? ST_WIN : ST_OUT;
            ST_WIN:      state_next = ST_MAX;
            ST_MAX:      state_next = ST_AUTO;
            ST_AUTO:     state_next = ST_MUL_A;
            ST_SCALE_WB: state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    assign in_accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // bin store: read at the current bin, written back after the blend
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (state_reg == ST_BIN_WB) begin
            bin_mem[bin_counter_reg] <= result_reg;
        end
        rd_data_reg <= bin_mem[bin_counter_reg];
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= 1'b0;
            bin_counter_reg <= '0;
            frame_peak_reg  <= '0;
            win_timer_reg   <= '0;
            win_slot_reg    <= '0;
            auto_level_reg  <= AMP_RESET;
            scale_level_reg <= AMP_RESET;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < NUM_BINS; i++) begin
                bin_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                win_max_reg[i] <= '0;
            end
        end else begin
            if (in_accept) begin
                phase_reg <= 1'b0;
            end
            if (state_reg == ST_BIN_WB) begin
                bin_valid_reg[bin_counter_reg] <= 1'b1;
                if (result_reg > frame_peak_reg) begin
                    frame_peak_reg <= result_reg;
                end
                bin_counter_reg <= last_bin ? '0 : bin_counter_reg + 1'b1;
            end
            if (state_reg == ST_WIN) begin
                win_timer_reg  <= win_rotate ? '0 : timer_sum;
                win_slot_reg   <= slot_new;
                // a fresh slot starts from zero, so it takes the frame peak
                if (win_rotate || (win_max_reg[slot_new] < frame_peak_reg)) begin
                    win_max_reg[slot_new] <= frame_peak_reg;
                end
                frame_peak_reg <= '0;
            end
            if (state_reg == ST_AUTO) begin
                auto_level_reg <= auto_new;
                phase_reg      <= 1'b1;
            end
            if (state_reg == ST_SCALE_WB) begin
                scale_level_reg <= result_reg;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            fresh_reg <= s_bin_value;
            e_reg     <= s_elapsed_ms;
        end
        if (state_reg == ST_READ) begin
            old_reg <= bin_valid_reg[bin_counter_reg] ? rd_data_reg : '0;
        end
        if (state_reg == ST_MUL_A) begin
            prod_a_reg <= PROD_W'(e_reg) * PROD_W'(fresh_reg);
        end
        if (state_reg == ST_MUL_B) begin
            prod_b_reg <= PROD_W'(blend_rest) * PROD_W'(old_reg);
        end
        if ((state_reg == ST_DIV_LOAD) && blend_bypass) begin
            result_reg <= fresh_reg;
        end else if ((state_reg == ST_DIV_WAIT) && div_sts.done) begin
            result_reg <= div_quo;
        end
        if (state_reg == ST_BIN_WB) begin
            smoothed_stage_reg <= result_reg;
            index_stage_reg    <= IDX_W'(bin_counter_reg);
            done_stage_reg     <= last_bin;
        end
        if (state_reg == ST_MAX) begin
            win_peak_reg <= win_peak;
        end
        // scale blend: move the current scale level toward the target
        if (state_reg == ST_AUTO) begin
            fresh_reg <= fixed_scale_reg ? user_amp_reg : auto_new;
            old_reg   <= scale_level_reg;
        end
        if (out_load) begin
            m_smoothed_reg <= smoothed_stage_reg;
            m_index_reg    <= index_stage_reg;
            m_done_reg     <= done_stage_reg;
            m_scale_reg    <= scale_level_reg;
            m_auto_reg     <= auto_level_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_smoothed_bin   = m_smoothed_reg;
    assign m_bin_index      = m_index_reg;
    assign m_frame_done     = m_done_reg;
    assign m_display_scale  = m_scale_reg;
    assign m_auto_amplitude = m_auto_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_bin_wb_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BIN_WB) |-> !phase_reg)
        else $error("bin writeback during scale blend");

    a_auto_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        auto_level_reg >= AMP_FLOOR)
        else $error("auto level below floor");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCALE_WB) |-> (bin_counter_reg == '0) && (frame_peak_reg == '0))
        else $error("frame state not cleared at scale update");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_sts.busy)
        else $error("divider started while busy");

endmodule

### dv/smoother_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smoother_checker
// watches the bin, result and register ports, predicts each smoothed bin and
// the frame-end window, auto level and scale update, and compares in order
// ----------------------------------------------------------------------------
module smoother_checker
    import ssa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MAG_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [MAG_W-1:0]     s_bin_value,
    input  logic [MS_W-1:0]      s_elapsed_ms,

    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [MAG_W-1:0]     m_smoothed_bin,
    input  logic [IDX_W-1:0]     m_bin_index,
    input  logic                 m_frame_done,
    input  logic [MAG_W-1:0]     m_display_scale,
    input  logic [MAG_W-1:0]     m_auto_amplitude,

    output int                   fail_count,
    output int                   pending_results
);

    typedef struct packed {
        logic [MAG_W-1:0] smoothed;
        logic [IDX_W-1:0] index;
        logic             done;
        logic [MAG_W-1:0] scale;
        logic [MAG_W-1:0] amplitude;
    } bin_result_t;

    bin_result_t expected_bins[$];
    int          mismatches = 0;

    // register copies
    logic             fixed_mode;
    logic [MAG_W-1:0] user_amp;
    logic [MS_W-1:0]  tc_ms;

    // smoother state
    logic [MAG_W-1:0]   bin_mem [NUM_BINS];
    logic [MAG_W-1:0]   win_max [NUM_WINDOWS];
    int unsigned        win_slot;
    logic [TIMER_W-1:0] win_timer;
    logic [MAG_W-1:0]   peak;
    int unsigned        bin_pos;
    logic [MAG_W-1:0]   auto_lvl;
    logic [MAG_W-1:0]   scale_lvl;

    // floor((e*fresh + (t-e)*old) / t), or fresh once the weight saturates
    function automatic logic [MAG_W-1:0] blend_q8(input logic [MAG_W-1:0] fresh,
                                                  input logic [MAG_W-1:0] old,
                                                  input logic [MS_W-1:0]  e,
                                                  input logic [MS_W-1:0]  t);
        logic [63:0] acc;
        if (e >= t)
            return fresh;
        acc = 64'(e) * 64'(fresh) + 64'(t - e) * 64'(old);
        return MAG_W'(acc / 64'(t));
    endfunction

    task automatic reset_model;
        int i;
        for (i = 0; i < NUM_BINS; i++)
            bin_mem[i] = '0;
        for (i = 0; i < NUM_WINDOWS; i++)
            win_max[i] = '0;
        win_slot   = 0;
        win_timer  = '0;
        peak       = '0;
        bin_pos    = 0;
        auto_lvl   = AMP_RESET;
        scale_lvl  = AMP_RESET;
        fixed_mode = 1'b0;
        user_amp   = AMP_RESET;
        tc_ms      = SMOOTH_RESET;
        expected_bins.delete();
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] index,
                             input logic [MAG_W-1:0] value);
        case (index)
            REG_FIXED_SCALE:    fixed_mode = value[0];
            REG_USER_AMPLITUDE: user_amp   = value;
            REG_SMOOTHING_TIME: tc_ms      = value[MS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic smooth_bin(input logic [MAG_W-1:0] x, input logic [MS_W-1:0] e);
        bin_result_t      r;
        logic [MAG_W-1:0] v;
        logic [MAG_W-1:0] top_max;
        logic [MAG_W-1:0] target;
        int unsigned      idx;
        int               i;
        idx = bin_pos;
        v = blend_q8(x, bin_mem[idx], e, tc_ms);
        bin_mem[idx] = v;
        if (v > peak)
            peak = v;
        r.done = (idx == NUM_BINS - 1);
        if (r.done) begin
            win_timer = win_timer + TIMER_W'(e);
            if (win_timer > WINDOW_MS) begin
                win_slot = (win_slot + 1) % NUM_WINDOWS;
                win_max[win_slot] = '0;
                win_timer = '0;
            end
            if (win_max[win_slot] < peak)
                win_max[win_slot] = peak;
            top_max = '0;
            for (i = 0; i < NUM_WINDOWS; i++)
                if (win_max[i] > top_max)
                    top_max = win_max[i];
            // drop only below 0.3 of the current level, rise at once
            if (64'(top_max) * 64'd10 < 64'(auto_lvl) * 64'd3)
                auto_lvl = top_max;
            else if (top_max > auto_lvl)
                auto_lvl = top_max;
            if (auto_lvl < AMP_FLOOR)
                auto_lvl = AMP_FLOOR;
            target = fixed_mode ? user_amp : auto_lvl;
            scale_lvl = blend_q8(target, scale_lvl, e, SCALE_TC_MS);
            peak = '0;
            bin_pos = 0;
        end else begin
            bin_pos = idx + 1;
        end
        r.smoothed  = v;
        r.index     = IDX_W'(idx);
        r.scale     = scale_lvl;
        r.amplitude = auto_lvl;
        expected_bins.push_back(r);
    endtask

    task automatic compare_result(input bin_result_t want);
        if (m_smoothed_bin !== want.smoothed) begin
            $error("smoothed_bin expected %0d actual %0d", want.smoothed, m_smoothed_bin);
            mismatches++;
        end
        if (m_bin_index !== want.index) begin
            $error("bin_index expected %0d actual %0d", want.index, m_bin_index);
            mismatches++;
        end
        if (m_frame_done !== want.done) begin
            $error("frame_done expected %0d actual %0d", want.done, m_frame_done);
            mismatches++;
        end
        if (m_display_scale !== want.scale) begin
            $error("display_scale expected %0d actual %0d", want.scale, m_display_scale);
            mismatches++;
        end
        if (m_auto_amplitude !== want.amplitude) begin
            $error("auto_amplitude expected %0d actual %0d", want.amplitude,
                   m_auto_amplitude);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_model();
        end else begin
            if (cfg_wr_en)
                write_cfg(cfg_index, cfg_wdata);
            if (s_valid && s_ready)
                smooth_bin(s_bin_value, s_elapsed_ms);
            if (m_valid && m_ready) begin
                if (expected_bins.size() == 0) begin
                    $error("unexpected result transaction, bin_index %0d", m_bin_index);
                    mismatches++;
                end else begin
                    compare_result(expected_bins.pop_front());
                end
            end
        end
        fail_count      <= mismatches;
        pending_results <= expected_bins.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives spectrum bins and register writes into the smoother with random
// gaps and result stalls; the checker beside the block predicts every result
// ----------------------------------------------------------------------------
module tb
    import ssa_pkg::*;
();

    // cycles with no transaction at all before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    // settle time after the last result
    localparam int TAIL_CYCLES = 200;
    localparam int PHASE_BINS  = 170;
    localparam int NUM_PHASES  = 7;
    // index past the register list, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MAG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [MAG_W-1:0]     s_bin_value;
    logic [MS_W-1:0]      s_elapsed_ms;
    logic                 m_valid;
    logic                 m_ready;
    logic [MAG_W-1:0]     m_smoothed_bin;
    logic [IDX_W-1:0]     m_bin_index;
    logic                 m_frame_done;
    logic [MAG_W-1:0]     m_display_scale;
    logic [MAG_W-1:0]     m_auto_amplitude;

    int fail_count;
    int pending_results;

    // calm phases run without any idling on either side
    bit               calm;
    int               bins_sent;
    int               idle_cycles;
    logic [MAG_W-1:0] mag_mask;
    logic [MS_W-1:0]  frame_ms;

    spectrum_smoother_autorange_top uut (.*);

    smoother_checker results_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit no_idle);
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one bin transaction; valid is only dropped when a gap precedes it
    task automatic send_bin(input logic [MAG_W-1:0] value, input logic [MS_W-1:0] ms);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_bin_value  <= value;
        s_elapsed_ms <= ms;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bins_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [MAG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // stop sending and wait for every predicted result to come back
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0)
            @(posedge aclk);
    endtask

    // loudness and frame time of a new frame
    task automatic new_frame;
        int roll;
        roll = $urandom_range(0, 99);
        // quiet frames pull the window maxima down so the auto level drops
        // through the hysteresis and reaches its floor
        if (roll < 35)
            mag_mask = MAG_W'((32'd1 << $urandom_range(4, 12)) - 1);
        else if (roll < 65)
            mag_mask = MAG_W'((32'd1 << $urandom_range(13, 18)) - 1);
        else
            mag_mask = MAG_W'((32'd1 << $urandom_range(19, 24)) - 1);
        roll = $urandom_range(0, 99);
        if (roll < 10)
            frame_ms = '0;
        else if (roll < 40)
            frame_ms = MS_W'($urandom_range(1, 60));
        else if (roll < 65)
            frame_ms = MS_W'($urandom_range(61, 600));
        else if (roll < 92)
            // over one second, rotates the window slot
            frame_ms = MS_W'($urandom_range(1001, 2500));
        else
            frame_ms = MS_W'($urandom);
    endtask

    // well-formed frames with one elapsed time each, plus some raw noise
    task automatic random_bins(input int count);
        int               n;
        logic [MAG_W-1:0] value;
        logic [MS_W-1:0]  ms;
        for (n = 0; n < count; n++) begin
            if (bins_sent % NUM_BINS == 0)
                new_frame();
            if ($urandom_range(0, 9) == 0) begin
                value = MAG_W'($urandom);
                ms    = MS_W'($urandom);
            end else begin
                value = MAG_W'($urandom) & mag_mask;
                ms    = frame_ms;
            end
            send_bin(value, ms);
        end
    endtask

    // result side pacing, ready held for a run then optionally stalled
    initial begin : result_pacing
        int run;
        int stall;
        forever begin
            run = $urandom_range(1, 24);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = pick_gap(calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // hang detection: no bin, result or register transaction for too long
    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL spectrum_smoother_autorange_top");
        $finish;
    end

    initial begin : stimulus
        int phase;
        calm         = 1'b0;
        bins_sent    = 0;
        mag_mask     = '1;
        frame_ms     = '0;
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= '0;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_bin_value  <= '0;
        s_elapsed_ms <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed bins under the reset registers (time constant 100 ms)
        send_bin(24'hFFFFFF, 16'hFFFF);
        send_bin(24'hFFFFFF, 16'd100);      // weight exactly one
        send_bin(24'hFFFFFF, 16'd99);       // just below saturation
        send_bin(24'h000000, 16'd1);
        send_bin(24'hFFFFFF, 16'd0);        // zero weight keeps the cleared entry
        send_bin(24'hFFFFFF, 16'd1);        // smallest nonzero weight
        send_bin(24'hAAAAAA, 16'hAAAA);
        send_bin(24'h555555, 16'h5555);
        send_bin(24'h800000, 16'd50);
        send_bin(24'h7FFFFF, 16'd51);
        send_bin(24'h000001, 16'd99);
        send_bin(24'h000000, 16'hFFFF);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            case (phase)
                0: begin
                    // zero time constant: low 16 bits clear, upper bits dropped
                    write_reg(REG_FIXED_SCALE, 24'hFFFFFE);
                    write_reg(REG_USER_AMPLITUDE, 24'hFFFFFF);
                    write_reg(REG_SMOOTHING_TIME, 24'h010000);
                    write_reg(REG_SPARE, MAG_W'($urandom));
                end
                1: begin
                    // user scale of zero, fastest smoothing
                    write_reg(REG_FIXED_SCALE, 24'h000001);
                    write_reg(REG_USER_AMPLITUDE, 24'h000000);
                    write_reg(REG_SMOOTHING_TIME, 24'h000001);
                end
                2: begin
                    // slowest smoothing, full user scale
                    write_reg(REG_FIXED_SCALE, 24'h000003);
                    write_reg(REG_USER_AMPLITUDE, 24'hFFFFFF);
                    write_reg(REG_SMOOTHING_TIME, 24'hFFFFFF);
                end
                3: begin
                    write_reg(REG_FIXED_SCALE, 24'h000000);
                    write_reg(REG_USER_AMPLITUDE, MAG_W'($urandom));
                    write_reg(REG_SMOOTHING_TIME, MAG_W'($urandom));
                end
                4: begin
                    write_reg(REG_FIXED_SCALE, MAG_W'($urandom));
                    write_reg(REG_USER_AMPLITUDE, MAG_W'($urandom));
                    write_reg(REG_SMOOTHING_TIME, MAG_W'($urandom_range(1, 1000)));
                end
                5: begin
                    // back to the reset settings
                    write_reg(REG_FIXED_SCALE, 24'h000000);
                    write_reg(REG_USER_AMPLITUDE, AMP_RESET);
                    write_reg(REG_SMOOTHING_TIME, SMOOTH_RESET);
                end
                default: begin
                    write_reg(REG_SPARE, MAG_W'($urandom));
                    write_reg(REG_FIXED_SCALE, MAG_W'($urandom));
                    write_reg(REG_USER_AMPLITUDE, MAG_W'($urandom));
                    write_reg(REG_SMOOTHING_TIME, MAG_W'($urandom_range(1, 400)));
                end
            endcase
            calm = (phase % 3 == 2);
            random_bins(PHASE_BINS);
        end

        calm = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0)
            $display("PASS spectrum_smoother_autorange_top");
        else
            $display("FAIL spectrum_smoother_autorange_top");
        $finish;
    end

endmodule

### filelist.f
sv/ssa_pkg.sv
sv/ssa_div.sv
sv/spectrum_smoother_autorange_top.sv
dv/smoother_checker.sv
dv/tb.sv
